FILE: design/smap_pkg.sv
// Shared constants, status codes and result type for the STUN mapped-address parser.
// No dependencies; compiled first.
`timescale 1ns / 1ps
`default_nettype none

package smap_pkg;

   // STUN header and attribute codes
   localparam int unsigned HDR_LEN = 20;
   localparam logic [15:0] TYPE_BINDING_OK = 16'h0101;
   localparam logic [15:0] ATTR_MAPPED = 16'h0001;
   localparam logic [15:0] ATTR_XOR_MAPPED = 16'h0020;
   localparam logic [15:0] XOR_PORT = 16'h2112;
   localparam logic [31:0] XOR_IP = 32'h2112a442;

   // Result status codes
   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_SHORT    = 2'd1,
      STATUS_BAD_TYPE = 2'd2,
      STATUS_NO_ADDR  = 2'd3
   } status_type;

   // One result word
   typedef struct packed {
      status_type  status;
      logic [31:0] mapped_ip;
      logic [15:0] mapped_port;
      logic        xor_form;
   } result_type;

endpackage

`default_nettype wire

FILE: design/smap_if.sv
// Valid/ready channel interfaces for the request byte stream and the result words.
// Depends on smap_pkg, which the result interface imports.
`timescale 1ns / 1ps
`default_nettype none

interface smap_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last_byte;

   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface smap_rsp_if;
   import smap_pkg::*;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [31:0] mapped_ip;
   logic [15:0] mapped_port;
   logic        xor_form;

   modport source (output valid, output status, output mapped_ip, output mapped_port,
                   output xor_form, input ready);
   modport sink (input valid, input status, input mapped_ip, input mapped_port,
                 input xor_form, output ready);
endinterface

`default_nettype wire

FILE: design/smap_parse.sv
// Per-byte STUN header and attribute walk; holds the parse state and forms the result.
// Depends on smap_pkg.
`timescale 1ns / 1ps
`default_nettype none

module smap_parse (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               word_valid,
   input  wire logic [7:0]         data_byte,
   input  wire logic               last_byte,
   output smap_pkg::result_type    result
);
   import smap_pkg::*;

   typedef enum logic [2:0] {
      PH_HEADER,
      PH_TYPE_HI,
      PH_TYPE_LO,
      PH_LEN_HI,
      PH_LEN_LO,
      PH_SKIP,
      PH_ADDR,
      PH_IDLE
   } phase_type;

   localparam logic [15:0] HdrLen16 = 16'(HDR_LEN);
   localparam logic [15:0] HdrLast16 = 16'(HDR_LEN - 1);

   logic [15:0] pos_ff, pos_in;
   logic [15:0] msg_type_ff, msg_type_in;
   logic [15:0] msg_len_ff, msg_len_in;
   logic [15:0] attr_type_ff, attr_type_in;
   logic [16:0] attr_rem_ff, attr_rem_in;
   phase_type   phase_ff, phase_in;
   logic [15:0] port_ff, port_in;
   logic [31:0] ip_ff, ip_in;
   logic        done_ff, done_in;

   logic [15:0] attr_len;
   logic [16:0] padded_len;
   logic [2:0]  addr_idx;
   logic        is_addr_type;

   assign attr_len = {attr_rem_ff[15:8], data_byte};
   assign padded_len = ({1'b0, attr_len} + 17'd3) & 17'h1FFFC;
   assign addr_idx = 3'(4'd8 - attr_rem_ff[3:0]);
   assign is_addr_type = (attr_type_ff == ATTR_MAPPED) || (attr_type_ff == ATTR_XOR_MAPPED);

   // Advance the parse state by one byte
   always_comb begin
      pos_in = (pos_ff == 16'hFFFF) ? pos_ff : pos_ff + 16'd1;
      msg_type_in = msg_type_ff;
      msg_len_in = msg_len_ff;
      attr_type_in = attr_type_ff;
      attr_rem_in = attr_rem_ff;
      phase_in = phase_ff;
      port_in = port_ff;
      ip_in = ip_ff;
      done_in = done_ff;
      unique case (phase_ff)
         PH_HEADER: begin
            if (pos_ff == 16'd0) begin
               msg_type_in = {data_byte, 8'h00};
            end else if (pos_ff == 16'd1) begin
               msg_type_in = {msg_type_ff[15:8], data_byte};
            end else if (pos_ff == 16'd2) begin
               msg_len_in = {data_byte, 8'h00};
            end else if (pos_ff == 16'd3) begin
               msg_len_in = {msg_len_ff[15:8], data_byte};
            end
            if (pos_ff == HdrLast16) begin
               phase_in = (msg_type_ff == TYPE_BINDING_OK) ? PH_TYPE_HI : PH_IDLE;
            end
         end
         PH_TYPE_HI: begin
            // stop once the attribute region is used up
            if ((pos_ff - HdrLen16) >= msg_len_ff) begin
               phase_in = PH_IDLE;
            end else begin
               attr_type_in = {data_byte, 8'h00};
               phase_in = PH_TYPE_LO;
            end
         end
         PH_TYPE_LO: begin
            attr_type_in = {attr_type_ff[15:8], data_byte};
            phase_in = PH_LEN_HI;
         end
         PH_LEN_HI: begin
            attr_rem_in = {1'b0, data_byte, 8'h00};
            phase_in = PH_LEN_LO;
         end
         PH_LEN_LO: begin
            // address attributes always read eight value bytes; others skip padded length
            if (is_addr_type) begin
               attr_rem_in = 17'd8;
               phase_in = PH_ADDR;
            end else begin
               attr_rem_in = padded_len;
               phase_in = (padded_len == 17'd0) ? PH_TYPE_HI : PH_SKIP;
            end
         end
         PH_SKIP: begin
            attr_rem_in = attr_rem_ff - 17'd1;
            if (attr_rem_ff == 17'd1) begin
               phase_in = PH_TYPE_HI;
            end
         end
         PH_ADDR: begin
            if (addr_idx == 3'd2 || addr_idx == 3'd3) begin
               port_in = {port_ff[7:0], data_byte};
            end else if (addr_idx >= 3'd4) begin
               ip_in = {ip_ff[23:0], data_byte};
            end
            attr_rem_in = attr_rem_ff - 17'd1;
            // final value byte: undo the XOR and close the walk
            if (attr_rem_ff == 17'd1) begin
               if (attr_type_ff == ATTR_XOR_MAPPED) begin
                  port_in = port_in ^ XOR_PORT;
                  ip_in = ip_in ^ XOR_IP;
               end
               done_in = 1'b1;
               phase_in = PH_IDLE;
            end
         end
         PH_IDLE: begin
         end
      endcase
   end

   // Form the result from the state after this byte
   always_comb begin
      result.mapped_ip = 32'd0;
      result.mapped_port = 16'd0;
      result.xor_form = 1'b0;
      if (pos_in < HdrLen16) begin
         result.status = STATUS_SHORT;
      end else if (msg_type_in != TYPE_BINDING_OK) begin
         result.status = STATUS_BAD_TYPE;
      end else if (!done_in || ip_in == 32'd0 || port_in == 16'd0) begin
         result.status = STATUS_NO_ADDR;
      end else begin
         result.status = STATUS_OK;
         result.mapped_ip = ip_in;
         result.mapped_port = port_in;
         result.xor_form = (attr_type_in == ATTR_XOR_MAPPED);
      end
   end

   // Hold parse state; clear it after the last byte of a datagram
   always_ff @(posedge clock) begin
      if (reset || (word_valid && last_byte)) begin
         pos_ff <= 16'd0;
         msg_type_ff <= 16'd0;
         msg_len_ff <= 16'd0;
         attr_type_ff <= 16'd0;
         attr_rem_ff <= 17'd0;
         phase_ff <= PH_HEADER;
         port_ff <= 16'd0;
         ip_ff <= 32'd0;
         done_ff <= 1'b0;
      end else if (word_valid) begin
         pos_ff <= pos_in;
         msg_type_ff <= msg_type_in;
         msg_len_ff <= msg_len_in;
         attr_type_ff <= attr_type_in;
         attr_rem_ff <= attr_rem_in;
         phase_ff <= phase_in;
         port_ff <= port_in;
         ip_ff <= ip_in;
         done_ff <= done_in;
      end
   end

endmodule

`default_nettype wire

FILE: design/stun_mapped_address_parser.sv
// STUN binding-response mapped-address parser: one UDP payload byte per word in, one
// result word per datagram out, issued for the word that carries the last-byte marker.
// The block takes one byte every cycle while no last byte is held back; a byte moves from
// the request register through the parse logic, and the result for a datagram is loaded
// into the result register as its last byte leaves the request register, and is offered
// on the response channel from then on. Only a result word left waiting on the response
// channel holds back the next last byte; other bytes keep flowing. The state is plain
// registers, so no warm-up is needed after reset.
// Depends on smap_pkg, smap_if and smap_parse.
`timescale 1ns / 1ps
`default_nettype none

module stun_mapped_address_parser (
   input wire logic   clock,
   input wire logic   reset,
   smap_req_if.sink   req_ch,
   smap_rsp_if.source rsp_ch
);
   import smap_pkg::*;

   logic       in_valid_ff;
   logic [7:0] in_byte_ff;
   logic       in_last_ff;
   logic       take;

   logic       rsp_valid_ff;
   result_type rsp_ff;
   result_type parse_result;

   // a byte leaves the input register unless it closes a datagram and the result is stuck
   assign take = in_valid_ff && (!in_last_ff || !rsp_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !in_valid_ff || take;

   // Hold the incoming word
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ch.ready) begin
         in_valid_ff <= req_ch.valid;
      end
      if (req_ch.ready && req_ch.valid) begin
         in_byte_ff <= req_ch.data_byte;
         in_last_ff <= req_ch.last_byte;
      end
   end

   smap_parse u_parse (
      .clock      (clock),
      .reset      (reset),
      .word_valid (take),
      .data_byte  (in_byte_ff),
      .last_byte  (in_last_ff),
      .result     (parse_result)
   );

   // Register the result word; drop it once taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (take && in_last_ff) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (take && in_last_ff) begin
         rsp_ff <= parse_result;
      end
   end

   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.status = rsp_ff.status;
   assign rsp_ch.mapped_ip = rsp_ff.mapped_ip;
   assign rsp_ch.mapped_port = rsp_ff.mapped_port;
   assign rsp_ch.xor_form = rsp_ff.xor_form;

`ifndef SYNTHESIS
   // a failed parse carries an all-zero payload
   a_zero_unless_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.status != STATUS_OK |->
         rsp_ff.mapped_ip == 32'd0 && rsp_ff.mapped_port == 16'd0 && !rsp_ff.xor_form)
      else $error("non-ok result carries a payload");

   // an ok result never reports a zero address or port
   a_ok_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.status == STATUS_OK |->
         rsp_ff.mapped_ip != 32'd0 && rsp_ff.mapped_port != 16'd0)
      else $error("ok result with zero address or port");

   // a held input word is not lost
   a_input_held: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !take |=> in_valid_ff && $stable(in_byte_ff) && $stable(in_last_ff))
      else $error("input word dropped while stalled");

   // a new result only follows a last byte
   a_result_from_last: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(take && in_last_ff))
      else $error("result issued without a last byte");
`endif

endmodule

`default_nettype wire

FILE: sim/smap_checker.sv
// Checker for the STUN mapped-address parser: watches both channels, predicts each result word
// from the accepted byte stream and compares it field by field. Depends on smap_pkg and smap_if.
`timescale 1ns / 1ps

module smap_checker (
   input  logic clock,
   input  logic reset,
   smap_req_if  req_mon,
   smap_rsp_if  rsp_mon,
   output int   fail_count,
   output int   pending
);
   import smap_pkg::*;

   typedef enum logic [2:0] {
      WALK_HEADER  = 3'd0,
      WALK_TYPE_HI = 3'd1,
      WALK_TYPE_LO = 3'd2,
      WALK_LEN_HI  = 3'd3,
      WALK_LEN_LO  = 3'd4,
      WALK_SKIP    = 3'd5,
      WALK_ADDR    = 3'd6,
      WALK_IDLE    = 3'd7
   } walk_phase_type;

   // predicted parser state
   logic [15:0]    byte_pos;
   logic [15:0]    msg_type;
   logic [15:0]    msg_len;
   logic [15:0]    attr_type;
   logic [16:0]    attr_left;
   walk_phase_type walk_phase;
   logic [15:0]    addr_port;
   logic [31:0]    addr_ip;
   logic           addr_taken;

   result_type awaited_results[$];
   int         mismatches = 0;

   // return the walk to its idle-line state
   task automatic clear_walk();
      byte_pos   = '0;
      msg_type   = '0;
      msg_len    = '0;
      attr_type  = '0;
      attr_left  = '0;
      walk_phase = WALK_HEADER;
      addr_port  = '0;
      addr_ip    = '0;
      addr_taken = 1'b0;
   endtask

   // advance the walk by one payload byte; on the last byte queue the datagram's result
   task automatic absorb_byte(input logic [7:0] b, input logic tail);
      int         k;
      result_type r;
      case (walk_phase)
         WALK_HEADER: begin
            case (byte_pos)
               16'd0: msg_type = {b, 8'h00};
               16'd1: msg_type = msg_type | {8'h00, b};
               16'd2: msg_len = {b, 8'h00};
               16'd3: msg_len = msg_len | {8'h00, b};
               default: ;
            endcase
            if (32'(byte_pos) == HDR_LEN - 1)
               walk_phase = (msg_type == TYPE_BINDING_OK) ? WALK_TYPE_HI : WALK_IDLE;
         end
         WALK_TYPE_HI: begin
            // stop once the attribute region is used up
            if (32'(byte_pos) - HDR_LEN >= 32'(msg_len)) begin
               walk_phase = WALK_IDLE;
            end else begin
               attr_type  = {b, 8'h00};
               walk_phase = WALK_TYPE_LO;
            end
         end
         WALK_TYPE_LO: begin
            attr_type  = attr_type | {8'h00, b};
            walk_phase = WALK_LEN_HI;
         end
         WALK_LEN_HI: begin
            attr_left  = {1'b0, b, 8'h00};
            walk_phase = WALK_LEN_LO;
         end
         WALK_LEN_LO: begin
            attr_left = attr_left | {9'h000, b};
            if (attr_type == ATTR_MAPPED || attr_type == ATTR_XOR_MAPPED) begin
               // the value is always read as eight bytes
               attr_left  = 17'd8;
               walk_phase = WALK_ADDR;
            end else begin
               attr_left  = (attr_left + 17'd3) & 17'h1FFFC;
               walk_phase = (attr_left == '0) ? WALK_TYPE_HI : WALK_SKIP;
            end
         end
         WALK_SKIP: begin
            attr_left = attr_left - 17'd1;
            if (attr_left == '0) walk_phase = WALK_TYPE_HI;
         end
         WALK_ADDR: begin
            k = 8 - int'(attr_left);
            if (k == 2 || k == 3) addr_port = {addr_port[7:0], b};
            else if (k >= 4) addr_ip = {addr_ip[23:0], b};
            attr_left = attr_left - 17'd1;
            if (attr_left == '0) begin
               if (attr_type == ATTR_XOR_MAPPED) begin
                  addr_port = addr_port ^ XOR_PORT;
                  addr_ip   = addr_ip ^ XOR_IP;
               end
               addr_taken = 1'b1;
               walk_phase = WALK_IDLE;
            end
         end
         default: ;
      endcase
      if (byte_pos != 16'hFFFF) byte_pos = byte_pos + 16'd1;

      if (tail) begin
         r = '0;
         if (32'(byte_pos) < HDR_LEN) begin
            r.status = STATUS_SHORT;
         end else if (msg_type != TYPE_BINDING_OK) begin
            r.status = STATUS_BAD_TYPE;
         end else if (!addr_taken || addr_ip == '0 || addr_port == '0) begin
            r.status = STATUS_NO_ADDR;
         end else begin
            r.status      = STATUS_OK;
            r.mapped_ip   = addr_ip;
            r.mapped_port = addr_port;
            r.xor_form    = (attr_type == ATTR_XOR_MAPPED);
         end
         awaited_results = {awaited_results, r};
         clear_walk();
      end
   endtask

   // check result words first, then take the new byte
   always @(posedge clock) begin
      result_type want;
      if (reset) begin
         clear_walk();
         awaited_results.delete();
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (awaited_results.size() == 0) begin
               $error("result word with none awaited: status %0d", rsp_mon.status);
               mismatches++;
            end else begin
               want = awaited_results.pop_front();
               if (rsp_mon.status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_mon.status);
                  mismatches++;
               end
               if (rsp_mon.mapped_ip !== want.mapped_ip) begin
                  $error("mapped_ip: expected %h, got %h", want.mapped_ip, rsp_mon.mapped_ip);
                  mismatches++;
               end
               if (rsp_mon.mapped_port !== want.mapped_port) begin
                  $error("mapped_port: expected %h, got %h",
                         want.mapped_port, rsp_mon.mapped_port);
                  mismatches++;
               end
               if (rsp_mon.xor_form !== want.xor_form) begin
                  $error("xor_form: expected %0d, got %0d", want.xor_form, rsp_mon.xor_form);
                  mismatches++;
               end
            end
         end
         if (req_mon.valid && req_mon.ready)
            absorb_byte(req_mon.data_byte, req_mon.last_byte);
      end
      pending    <= awaited_results.size();
      fail_count <= mismatches;
   end

endmodule

FILE: sim/tb_stun_mapped_address_parser.sv
// Testbench top for the STUN mapped-address parser: builds datagrams, drives them byte by byte
// with random gaps and stalls, and reports the verdict. Depends on smap_pkg, smap_if, smap_checker.
`timescale 1ns / 1ps

module tb_stun_mapped_address_parser;
   import smap_pkg::*;

   localparam int STALL_LIMIT = 400;

   logic clock;
   logic reset;
   int   fail_count;
   int   pending;
   int   idle_cycles = 0;

   bit   calm = 1'b0;
   bit   sender_gaps = 1'b0;
   int   sent_bytes = 0;
   int   random_datagrams = 0;

   logic [7:0] datagram[$];

   smap_req_if req_if ();
   smap_rsp_if rsp_if ();

   stun_mapped_address_parser u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if),
      .rsp_ch (rsp_if)
   );

   smap_checker u_check (
      .clock      (clock),
      .reset      (reset),
      .req_mon    (req_if),
      .rsp_mon    (rsp_if),
      .fail_count (fail_count),
      .pending    (pending)
   );

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   // end the run if nothing moves on either channel for too long
   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("tb_stun_mapped_address_parser: done, errors");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // result side: stall in bursts, hold ready high once calm
   initial begin
      rsp_if.ready <= 1'b0;
      @(posedge clock);
      forever begin
         if (calm) begin
            rsp_if.ready <= 1'b1;
            @(posedge clock);
         end else if ($urandom_range(0, 2) == 0) begin
            rsp_if.ready <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clock);
         end else if ($urandom_range(0, 5) == 0) begin
            rsp_if.ready <= 1'b1;
            repeat ($urandom_range(50, 150)) @(posedge clock);
         end else begin
            rsp_if.ready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge clock);
         end
      end
   end

   // append one byte to the datagram under construction
   task automatic add_byte(input logic [7:0] v);
      datagram = {datagram, v};
   endtask

   task automatic put16(input logic [15:0] v);
      add_byte(v[15:8]);
      add_byte(v[7:0]);
   endtask

   // header with a zero length field; patch_length fills it in
   task automatic put_header(input logic [15:0] mtype);
      logic [31:0] cookie;
      cookie = ($urandom_range(0, 4) == 0) ? $urandom : XOR_IP;
      datagram.delete();
      put16(mtype);
      put16(16'h0000);
      put16(cookie[31:16]);
      put16(cookie[15:0]);
      repeat (12) add_byte(8'($urandom));
   endtask

   task automatic patch_length(input logic [15:0] len);
      datagram[2] = len[15:8];
      datagram[3] = len[7:0];
   endtask

   // skipped attribute, value padded to a multiple of four
   task automatic put_unknown(input logic [15:0] atype, input logic [15:0] alen);
      put16(atype);
      put16(alen);
      repeat (((int'(alen) + 3) / 4) * 4) add_byte(8'($urandom));
   endtask

   // address attribute given by its decoded port and address
   task automatic put_address(input logic [15:0] atype, input logic [15:0] alen,
                              input logic [15:0] port, input logic [31:0] ip);
      if (atype == ATTR_XOR_MAPPED) begin
         port = port ^ XOR_PORT;
         ip   = ip ^ XOR_IP;
      end
      put16(atype);
      put16(alen);
      add_byte(8'($urandom));
      add_byte(($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'h01);
      put16(port);
      put16(ip[31:16]);
      put16(ip[15:0]);
   endtask

   // binding success with random attributes around at most one address attribute
   task automatic build_binding();
      logic [15:0] atype;
      logic [15:0] len;
      int          addr_at;
      put_header(TYPE_BINDING_OK);
      repeat ($urandom_range(0, 2)) begin
         atype = 16'($urandom);
         if (atype == ATTR_MAPPED || atype == ATTR_XOR_MAPPED) atype[15] = 1'b1;
         put_unknown(atype, ($urandom_range(0, 4) == 0) ? 16'($urandom_range(0, 40))
                                                        : 16'($urandom_range(0, 12)));
      end
      addr_at = datagram.size() - HDR_LEN;
      if ($urandom_range(0, 9) != 0)
         put_address($urandom_range(0, 1) ? ATTR_XOR_MAPPED : ATTR_MAPPED,
                     ($urandom_range(0, 9) == 0) ? 16'($urandom_range(0, 16)) : 16'd8,
                     ($urandom_range(0, 15) == 0) ? 16'h0000 : 16'($urandom),
                     ($urandom_range(0, 15) == 0) ? 32'h0 : 32'($urandom));
      if ($urandom_range(0, 3) == 0) put_unknown(16'($urandom), 16'($urandom_range(0, 12)));
      case ($urandom_range(0, 9))
         0: len = 16'(addr_at);
         1: len = 16'($urandom_range(0, 48));
         2: len = 16'($urandom);
         default: len = 16'(datagram.size() - HDR_LEN);
      endcase
      patch_length(len);
   endtask

   task automatic send_byte(input logic [7:0] value, input logic tail);
      int gap;
      gap = 0;
      if (sender_gaps && $urandom_range(0, 4) == 0) gap = $urandom_range(1, 7);
      if (gap != 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid     <= 1'b1;
      req_if.data_byte <= value;
      req_if.last_byte <= tail;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
   endtask

   task automatic send_datagram();
      sender_gaps = !calm && ($urandom_range(0, 3) != 0);
      foreach (datagram[i]) send_byte(datagram[i], i == datagram.size() - 1);
      sent_bytes += datagram.size();
   endtask

   // drop valid and wait for every awaited result word
   task automatic hold_until_drained();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   initial begin
      int          cut;
      logic [15:0] bad_type;

      reset            <= 1'b1;
      req_if.valid     <= 1'b0;
      req_if.data_byte <= 8'h00;
      req_if.last_byte <= 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // one-byte datagram, then one byte short of a header
      datagram = {8'hFF};
      send_datagram();
      datagram.delete();
      repeat (19) add_byte(8'h00);
      send_datagram();

      // bare headers: wrong type, then binding success with no attributes
      put_header(16'hFFFF);
      send_datagram();
      put_header(TYPE_BINDING_OK);
      send_datagram();

      // all-ones value bytes in the XOR form
      put_header(TYPE_BINDING_OK);
      put_address(ATTR_XOR_MAPPED, 16'd8, 16'hDEED, 32'hDEED5BBD);
      patch_length(16'(datagram.size() - HDR_LEN));
      send_datagram();

      // plain form with an attribute length too short for its value
      put_header(TYPE_BINDING_OK);
      put_address(ATTR_MAPPED, 16'd4, 16'hFFFF, 32'hFFFFFFFF);
      patch_length(16'(datagram.size() - HDR_LEN));
      send_datagram();

      // the first address attribute, with a zero address, ends the walk; the second one is ignored
      put_header(TYPE_BINDING_OK);
      put_address(ATTR_MAPPED, 16'd8, 16'h1234, 32'h0);
      put_address(ATTR_XOR_MAPPED, 16'd8, 16'h4321, 32'h0A000001);
      patch_length(16'(datagram.size() - HDR_LEN));
      send_datagram();

      // datagram ends inside the address value
      put_header(TYPE_BINDING_OK);
      put_address(ATTR_XOR_MAPPED, 16'd8, 16'hBEEF, 32'hC0A80001);
      patch_length(16'(datagram.size() - HDR_LEN));
      repeat (3) void'(datagram.pop_back());
      send_datagram();

      // padded skip of an odd-length attribute
      put_header(TYPE_BINDING_OK);
      put_unknown(16'h8022, 16'd5);
      put_address(ATTR_MAPPED, 16'd8, 16'h0001, 32'h00000001);
      patch_length(16'(datagram.size() - HDR_LEN));
      send_datagram();

      // address attribute beyond the message length
      put_header(TYPE_BINDING_OK);
      put_unknown(16'h0006, 16'd8);
      put_address(ATTR_XOR_MAPPED, 16'd8, 16'h0F0F, 32'h7F000001);
      patch_length(16'd12);
      send_datagram();

      hold_until_drained();

      // random datagrams, mostly well formed
      while (sent_bytes < 1150 || random_datagrams < 20) begin
         case ($urandom_range(0, 9))
            0: begin
               datagram.delete();
               repeat ($urandom_range(1, 19)) add_byte(8'($urandom));
            end
            1: begin
               datagram.delete();
               repeat ($urandom_range(20, 40)) add_byte(8'($urandom));
               if ($urandom_range(0, 1) == 0) begin
                  datagram[0] = TYPE_BINDING_OK[15:8];
                  datagram[1] = TYPE_BINDING_OK[7:0];
               end
            end
            2: begin
               build_binding();
               bad_type = ($urandom_range(0, 1) == 0)
                        ? TYPE_BINDING_OK ^ (16'h0001 << $urandom_range(0, 15))
                        : 16'($urandom);
               if (bad_type == TYPE_BINDING_OK) bad_type = 16'h0111;
               datagram[0] = bad_type[15:8];
               datagram[1] = bad_type[7:0];
            end
            3: begin
               build_binding();
               cut = $urandom_range(1, datagram.size() - 1);
               while (datagram.size() > cut) void'(datagram.pop_back());
            end
            default: build_binding();
         endcase
         if (!calm && random_datagrams % 16 == 8) hold_until_drained();
         if (sent_bytes >= 1000 && random_datagrams >= 16) calm = 1'b1;
         send_datagram();
         random_datagrams++;
      end

      hold_until_drained();
      repeat (8) @(posedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("tb_stun_mapped_address_parser: done, clean");
      end else begin
         $display("tb_stun_mapped_address_parser: done, errors");
      end
      $finish;
   end

endmodule

FILE: stun_mapped_address_parser.f
design/smap_pkg.sv
design/smap_if.sv
design/smap_parse.sv
design/stun_mapped_address_parser.sv
sim/smap_checker.sv
sim/tb_stun_mapped_address_parser.sv
